### hdl/scc_pkg.sv
// Shared package for the sunset color curve block.
// Holds register indexes, reset values, datapath widths and inter-module structs.
// No dependencies.
`default_nettype none
package scc_pkg;
	localparam int STEP_W  = 16;
	localparam int COLOR_W = 24;
	localparam int CH_W    = 8;
	localparam int SQ_W    = 2 * STEP_W;
	localparam int PROD_W  = SQ_W + CH_W;
	localparam int NUM_W   = PROD_W + 2;
	localparam int REM_W   = 48;
	localparam int DEN_W   = 40;
	localparam int IDX_W   = 4;
	localparam int LAT     = 5 + CH_W;
	localparam int SCALE   = 200;

	localparam logic [IDX_W-1:0] REG_FIRST_STEP  = 4'd0;
	localparam logic [IDX_W-1:0] REG_MIDDLE_STEP = 4'd1;
	localparam logic [IDX_W-1:0] REG_LAST_STEP   = 4'd2;
	localparam logic [IDX_W-1:0] REG_START_COLOR = 4'd3;
	localparam logic [IDX_W-1:0] REG_CTRL_ONE    = 4'd4;
	localparam logic [IDX_W-1:0] REG_JOINT_COLOR = 4'd5;
	localparam logic [IDX_W-1:0] REG_CTRL_TWO    = 4'd6;
	localparam logic [IDX_W-1:0] REG_END_COLOR   = 4'd7;

	localparam logic [STEP_W-1:0]  RST_FIRST  = 16'd0;
	localparam logic [STEP_W-1:0]  RST_MIDDLE = 16'd512;
	localparam logic [STEP_W-1:0]  RST_LAST   = 16'd1023;
	localparam logic [COLOR_W-1:0] RST_BLACK  = 24'h000000;
	localparam logic [COLOR_W-1:0] RST_WHITE  = 24'hFFFFFF;

	// Bezier weights of one step: (D-d)^2, (D-d)*d, d^2 and D^2
	typedef struct packed {
		logic [SQ_W-1:0] a;
		logic [SQ_W-1:0] b;
		logic [SQ_W-1:0] c;
		logic [SQ_W-1:0] dd;
	} scc_coef_t;

	// Segment control points and the flat-color bypass
	typedef struct packed {
		logic               byp;
		logic [COLOR_W-1:0] col;
		logic [COLOR_W-1:0] p0;
		logic [COLOR_W-1:0] p1;
		logic [COLOR_W-1:0] p2;
	} scc_sel_t;
endpackage
`default_nettype wire

### hdl/scc_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit.
// Depends on scc_pkg.
`default_nettype none
module scc_div_cell #(
	parameter int SH = 7
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [scc_pkg::REM_W-1:0] rem_i,
	input  logic [scc_pkg::DEN_W-1:0] den_i,
	input  logic [scc_pkg::CH_W-1:0]  quo_i,
	output logic [scc_pkg::REM_W-1:0] rem_o,
	output logic [scc_pkg::DEN_W-1:0] den_o,
	output logic [scc_pkg::CH_W-1:0]  quo_o
);
	import scc_pkg::*;

	logic [REM_W-1:0] sh_den;
	logic             ge;
	logic [CH_W-1:0]  quo_nx;

	always_comb begin
		sh_den     = REM_W'(den_i) << SH;
		ge         = rem_i >= sh_den;
		quo_nx     = quo_i;
		quo_nx[SH] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - sh_den : rem_i;
			den_o <= den_i;
			quo_o <= quo_nx;
		end
	end
endmodule
`default_nettype wire

### hdl/scc_front.sv
// Segment selection and Bezier weight squares (stages one and two).
// Depends on scc_pkg.
`default_nettype none
module scc_front (
	input  logic                        clk,
	input  logic                        en,
	input  logic [scc_pkg::STEP_W-1:0]  step,
	input  logic [scc_pkg::STEP_W-1:0]  first_step,
	input  logic [scc_pkg::STEP_W-1:0]  middle_step,
	input  logic [scc_pkg::STEP_W-1:0]  last_step,
	input  logic [scc_pkg::COLOR_W-1:0] start_color,
	input  logic [scc_pkg::COLOR_W-1:0] control_one_color,
	input  logic [scc_pkg::COLOR_W-1:0] joint_color,
	input  logic [scc_pkg::COLOR_W-1:0] control_two_color,
	input  logic [scc_pkg::COLOR_W-1:0] end_color,
	output scc_pkg::scc_coef_t          coef_s2,
	output scc_pkg::scc_sel_t           sel_s2
);
	import scc_pkg::*;

	logic              lo, hi, seg1;
	logic [STEP_W-1:0] d_nx, span_nx;
	scc_sel_t          sel_nx, sel_s1;
	logic [STEP_W-1:0] d_s1, rest_s1, span_s1;

	always_comb begin
		lo      = step < first_step;
		hi      = step > last_step;
		seg1    = step <= middle_step;
		d_nx    = seg1 ? step - first_step : step - middle_step;
		span_nx = seg1 ? middle_step - first_step : last_step - middle_step;
		sel_nx.p0  = seg1 ? start_color : joint_color;
		sel_nx.p1  = seg1 ? control_one_color : control_two_color;
		sel_nx.p2  = seg1 ? joint_color : end_color;
		// below start, above end and zero span all give a flat color
		sel_nx.byp = lo || hi || (span_nx == '0);
		sel_nx.col = lo ? start_color : (hi ? end_color : sel_nx.p2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1  <= sel_nx;
			d_s1    <= d_nx;
			rest_s1 <= span_nx - d_nx;
			span_s1 <= span_nx;
			sel_s2  <= sel_s1;
			coef_s2.a  <= SQ_W'(rest_s1) * SQ_W'(rest_s1);
			coef_s2.b  <= SQ_W'(rest_s1) * SQ_W'(d_s1);
			coef_s2.c  <= SQ_W'(d_s1) * SQ_W'(d_s1);
			coef_s2.dd <= SQ_W'(span_s1) * SQ_W'(span_s1);
		end
	end
endmodule
`default_nettype wire

### hdl/scc_chan.sv
// One color channel: weighted sum, rounding setup and the divider cell chain.
// Depends on scc_pkg and scc_div_cell.
`default_nettype none
module scc_chan (
	input  logic                     clk,
	input  logic                     en,
	input  scc_pkg::scc_coef_t       coef,
	input  logic                     byp,
	input  logic [scc_pkg::CH_W-1:0] col,
	input  logic [scc_pkg::CH_W-1:0] p0,
	input  logic [scc_pkg::CH_W-1:0] p1,
	input  logic [scc_pkg::CH_W-1:0] p2,
	output logic [scc_pkg::CH_W-1:0] quo
);
	import scc_pkg::*;

	logic [PROD_W-1:0] ta_s3, tb_s3, tc_s3;
	logic [SQ_W-1:0]   dd_s3, dd_s4;
	logic              byp_s3, byp_s4;
	logic [CH_W-1:0]   col_s3, col_s4;
	logic [NUM_W-1:0]  n_s4;
	logic [REM_W-1:0]  rem_s5;
	logic [DEN_W-1:0]  den_s5;
	logic [REM_W-1:0]  rem_c [0:CH_W];
	logic [DEN_W-1:0]  den_c [0:CH_W];
	logic [CH_W-1:0]   quo_c [0:CH_W];

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s3  <= PROD_W'(coef.a) * PROD_W'(p0);
			tb_s3  <= PROD_W'(coef.b) * PROD_W'(p1);
			tc_s3  <= PROD_W'(coef.c) * PROD_W'(p2);
			dd_s3  <= coef.dd;
			byp_s3 <= byp;
			col_s3 <= col;
			n_s4   <= NUM_W'(ta_s3) + (NUM_W'(tb_s3) << 1) + NUM_W'(tc_s3);
			dd_s4  <= dd_s3;
			byp_s4 <= byp_s3;
			col_s4 <= col_s3;
			// flat color: divide SCALE*col+1 by SCALE to get col back
			if (byp_s4) begin
				rem_s5 <= REM_W'(col_s4) * REM_W'(SCALE) + REM_W'(1);
				den_s5 <= DEN_W'(SCALE);
			end else begin
				rem_s5 <= REM_W'(n_s4) * REM_W'(SCALE) + REM_W'(dd_s4);
				den_s5 <= DEN_W'(dd_s4) * DEN_W'(SCALE);
			end
		end
	end

	assign rem_c[0] = rem_s5;
	assign den_c[0] = den_s5;
	assign quo_c[0] = '0;

	for (genvar k = 0; k < CH_W; k++) begin : g_cell
		scc_div_cell #(.SH(CH_W - 1 - k)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_c[k]),
			.den_i (den_c[k]),
			.quo_i (quo_c[k]),
			.rem_o (rem_c[k+1]),
			.den_o (den_c[k+1]),
			.quo_o (quo_c[k+1])
		);
	end

	assign quo = quo_c[CH_W];
endmodule
`default_nettype wire

### hdl/sunset_color_curve.sv
// Top level of the sunset color curve: config registers, pipeline control
// and three channel datapaths. Depends on scc_pkg, scc_front and scc_chan.
//
// Usage:
//   Input channel in_valid/in_ready carries one step per beat. The output
//   channel out_valid/out_ready carries one red/green/blue beat per step, in
//   order. Steps below first_step give start_color, above last_step give
//   end_color; otherwise the color follows one of two quadratic Bezier
//   segments, with 1/200 added before the result is floored.
//   Config: cfg_valid/cfg_ready with cfg_index (register 0..7) and cfg_data;
//   cfg_ready is always high, indexes above 7 are dropped. Write only while
//   no step is in flight.
//   Pipeline: two stages of selection and squaring, three of products and
//   scaling, then one cell per quotient bit in the eight-cell restoring
//   divider chain, from input beat to output beat.
//   Throughput: one step per cycle while not stalled; every stage advances together.
//   Stall: while out_valid is high and out_ready low, the whole pipe holds
//   and in_ready drops; bubbles hold their place and advance with the rest.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (curve 0..512..1023, black to white end colors).
`default_nettype none
module sunset_color_curve (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [scc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [scc_pkg::COLOR_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [scc_pkg::STEP_W-1:0]  step,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [scc_pkg::CH_W-1:0]    red,
	output logic [scc_pkg::CH_W-1:0]    green,
	output logic [scc_pkg::CH_W-1:0]    blue
);
	import scc_pkg::*;

	logic [STEP_W-1:0]  first_q, middle_q, last_q;
	logic [COLOR_W-1:0] start_q, ctrl1_q, joint_q, ctrl2_q, end_q;
	logic [LAT-1:0]     vld_q;
	logic               en;
	scc_coef_t          coef_s2;
	scc_sel_t           sel_s2;

	assign cfg_ready = 1'b1;

	// Register file; out-of-range indexes fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= RST_FIRST;
			middle_q <= RST_MIDDLE;
			last_q   <= RST_LAST;
			start_q  <= RST_BLACK;
			ctrl1_q  <= RST_BLACK;
			joint_q  <= RST_BLACK;
			ctrl2_q  <= RST_BLACK;
			end_q    <= RST_WHITE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_STEP:  first_q  <= cfg_data[STEP_W-1:0];
				REG_MIDDLE_STEP: middle_q <= cfg_data[STEP_W-1:0];
				REG_LAST_STEP:   last_q   <= cfg_data[STEP_W-1:0];
				REG_START_COLOR: start_q  <= cfg_data;
				REG_CTRL_ONE:    ctrl1_q  <= cfg_data;
				REG_JOINT_COLOR: joint_q  <= cfg_data;
				REG_CTRL_TWO:    ctrl2_q  <= cfg_data;
				REG_END_COLOR:   end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless a finished beat waits at the head
	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	scc_front u_front (
		.clk               (clk),
		.en                (en),
		.step              (step),
		.first_step        (first_q),
		.middle_step       (middle_q),
		.last_step         (last_q),
		.start_color       (start_q),
		.control_one_color (ctrl1_q),
		.joint_color       (joint_q),
		.control_two_color (ctrl2_q),
		.end_color         (end_q),
		.coef_s2           (coef_s2),
		.sel_s2            (sel_s2)
	);

	scc_chan u_red (
		.clk (clk), .en (en), .coef (coef_s2), .byp (sel_s2.byp),
		.col (sel_s2.col[23:16]), .p0 (sel_s2.p0[23:16]),
		.p1 (sel_s2.p1[23:16]), .p2 (sel_s2.p2[23:16]), .quo (red)
	);

	scc_chan u_green (
		.clk (clk), .en (en), .coef (coef_s2), .byp (sel_s2.byp),
		.col (sel_s2.col[15:8]), .p0 (sel_s2.p0[15:8]),
		.p1 (sel_s2.p1[15:8]), .p2 (sel_s2.p2[15:8]), .quo (green)
	);

	scc_chan u_blue (
		.clk (clk), .en (en), .coef (coef_s2), .byp (sel_s2.byp),
		.col (sel_s2.col[7:0]), .p0 (sel_s2.p0[7:0]),
		.p1 (sel_s2.p1[7:0]), .p2 (sel_s2.p2[7:0]), .quo (blue)
	);
endmodule
`default_nettype wire

### hdl/scc_checker.sv
// Port-level checker for the sunset color curve, bound to the top level.
// Depends on scc_pkg.
`default_nettype none
module scc_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [scc_pkg::CH_W-1:0] red,
	input logic [scc_pkg::CH_W-1:0] green,
	input logic [scc_pkg::CH_W-1:0] blue
);
	import scc_pkg::*;

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("output beat changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty head");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while head stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");
endmodule

bind sunset_color_curve scc_checker u_scc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
`default_nettype wire
